// File: rtl/ssbg_pkg.sv
// Package for the spectral subtraction bin gain block.
// Field widths, fixed-point shifts and the output saturation helper.
// No dependencies.
package ssbg_pkg;

	localparam int SW        = 24;          // bin part width
	localparam int PW        = 2 * SW;      // bin power width
	localparam int SUM_W     = 52;          // noise sum width
	localparam int FAC_W     = 16;          // alpha and beta width
	localparam int ACC_W     = FAC_W + SUM_W;
	localparam int ALPHA_SH  = 12;
	localparam int BETA_SH   = 16;
	localparam int A_W       = ACC_W - ALPHA_SH;
	localparam int SQRT_SH   = 10;
	localparam int SQ_W      = SUM_W + SQRT_SH;   // square root radicand
	localparam int RT_W      = SQ_W / 2;          // root width
	localparam int PROD_W    = SW + RT_W;
	localparam int DIV_NW    = PROD_W + 1;
	localparam int DIV_DW    = RT_W;
	localparam int DEF_BINS  = 256;
	localparam int DEF_MAXF  = 15;
	localparam logic [FAC_W-1:0] BETA_RST = 16'd3277;

	localparam logic [SW-1:0] OUT_HI = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] OUT_LO = {1'b1, {(SW-1){1'b0}}};

	typedef struct packed {
		logic [SW-1:0] v;
		logic          clip;
	} part_t;

	function automatic part_t sat_part(input logic neg, input logic [DIV_NW-1:0] q);
		part_t r;
		r.clip = 1'b0;
		if (!neg) begin
			if (q > DIV_NW'(OUT_HI)) begin
				r.v    = OUT_HI;
				r.clip = 1'b1;
			end else begin
				r.v = q[SW-1:0];
			end
		end else begin
			if (q > {{(DIV_NW-SW){1'b0}}, OUT_LO}) begin
				r.v    = OUT_LO;
				r.clip = 1'b1;
			end else begin
				r.v = SW'(~q[SW-1:0] + 1'b1);
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/ssbg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ssbg_pkg for default widths.
module ssbg_div import ssbg_pkg::*; #(
	parameter int NW = DIV_NW,
	parameter int DW = DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/ssbg_isqrt.sv
// Floor square root, two radicand bits per cycle.
// Depends on ssbg_pkg for the default width.
module ssbg_isqrt import ssbg_pkg::*; #(
	parameter int W = SQ_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   rad,
	output logic           done,
	output logic [W/2-1:0] root
);

	localparam int HW = W / 2;
	localparam int CW = $clog2(HW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rad_q;
	logic [HW-1:0] root_q;
	logic [HW+1:0] rem_q;
	logic [HW+1:0] remsh;
	logic [HW+1:0] trial;
	logic          ge;

	assign remsh = {rem_q[HW-1:0], rad_q[W-1:W-2]};
	assign trial = {root_q, 2'b01};
	assign ge    = remsh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(HW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[W-3:0], 2'b00};
			root_q <= {root_q[HW-2:0], ge};
			rem_q  <= ge ? remsh - trial : remsh;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/spectral_subtraction_bin_gain.sv
// Spectral subtraction gain stage: top level with sequencer and noise sum memory.
// Depends on ssbg_pkg, ssbg_div and ssbg_isqrt.
//
// Input channel bin_valid/bin_ready carries one complex FFT bin per beat with its
// over-subtraction factor and last-bin mark. Result channel res_valid/res_ready
// carries one denoised bin per beat, only for bins taken in denoise mode.
// Registers over APB: learn_mode at 0x0, floor_beta at 0x4; pready is always high.
// One bin is processed at a time. A learn-mode beat passes through accept, read and
// write back to the noise sum memory. A denoise beat, once noise has been learned,
// uses the bit-serial divider (noise average and two scale divisions), two 16-step
// shift-add multiplies and the square root unit (two roots). With no frame learned
// the noise division is skipped; a zero bin skips the second root and the scale
// divisions. The result is valid the cycle after the sequencer finishes, and the
// next bin can be taken then.
// After reset the noise sum memory is cleared, one entry a cycle; bin_ready
// stays low meanwhile. A finished result waits in the output register while the
// next bin is accepted; if the receiver stalls, the sequencer holds the
// following result until the register frees.
module spectral_subtraction_bin_gain import ssbg_pkg::*; #(
	parameter int BINS             = DEF_BINS,
	parameter int MAX_NOISE_FRAMES = DEF_MAXF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bin_valid,
	output logic                 bin_ready,
	input  logic signed [SW-1:0] bin_re,
	input  logic signed [SW-1:0] bin_im,
	input  logic [FAC_W-1:0]     sub_factor,
	input  logic                 frame_end,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic signed [SW-1:0] clean_re,
	output logic signed [SW-1:0] clean_im,
	output logic                 frame_end_out,
	output logic                 clipped,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int PSW = $clog2(BINS);
	localparam int FW  = $clog2(MAX_NOISE_FRAMES + 1);
	localparam int MCW = $clog2(FAC_W);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_WB   = 4'd2;
	localparam logic [3:0] ST_DIVN = 4'd3;
	localparam logic [3:0] ST_MULA = 4'd4;
	localparam logic [3:0] ST_MULF = 4'd5;
	localparam logic [3:0] ST_CLN  = 4'd6;
	localparam logic [3:0] ST_SQS  = 4'd7;
	localparam logic [3:0] ST_SQM  = 4'd8;
	localparam logic [3:0] ST_MULR = 4'd9;
	localparam logic [3:0] ST_STR  = 4'd10;
	localparam logic [3:0] ST_DVR  = 4'd11;
	localparam logic [3:0] ST_MULI = 4'd12;
	localparam logic [3:0] ST_STI  = 4'd13;
	localparam logic [3:0] ST_DVI  = 4'd14;
	localparam logic [3:0] ST_OUT  = 4'd15;

	// config registers
	logic             learn_q;
	logic [FAC_W-1:0] beta_q;
	logic             cfg_wr;

	// control
	logic [3:0]     state_q;
	logic           clr_busy_q;
	logic [PSW-1:0] clr_q;
	logic [PSW-1:0] pos_q;
	logic [FW-1:0]  frames_q;
	logic [MCW-1:0] mcnt_q;
	logic           res_valid_q;
	logic           bin_accept;

	// payload
	logic signed [SW-1:0] re_s1;
	logic signed [SW-1:0] im_s1;
	logic [FAC_W-1:0]     alpha_s1;
	logic                 fend_s1;
	logic                 learn_s1;
	logic [PSW-1:0]       pos_s1;
	logic [PW-1:0]        p_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SUM_W-1:0]     n_q;
	logic [ACC_W-1:0]     acc_q;
	logic [FAC_W-1:0]     fac_q;
	logic [A_W-1:0]       a_q;
	logic [SUM_W-1:0]     f_q;
	logic [RT_W-1:0]      s_q;
	logic [RT_W-1:0]      m_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DIV_NW-1:0]    qre_q;
	logic [DIV_NW-1:0]    qim_q;
	logic [SW-1:0]        ore_q;
	logic [SW-1:0]        oim_q;
	logic                 ofend_q;
	logic                 oclip_q;

	// memory
	logic [SUM_W-1:0] mem [BINS];
	logic [SUM_W-1:0] rdata_q;
	logic             mem_we;
	logic [PSW-1:0]   mem_wa;
	logic [SUM_W-1:0] mem_wd;

	// datapath
	logic [SW-1:0]     mag_re;
	logic [SW-1:0]     mag_im;
	logic [PW-1:0]     sq_re;
	logic [PW-1:0]     sq_im;
	logic [PW-1:0]     p_nx;
	logic [SW-1:0]     mul_op;
	logic [PROD_W-1:0] prod_nx;
	logic [SUM_W:0]    sum_add;
	logic [ACC_W-1:0]  acc_nx;
	logic [A_W-1:0]    p_ext;
	logic [A_W-1:0]    t_sub;
	logic [SUM_W-1:0]  c_nx;
	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;
	logic              sq_start;
	logic [SQ_W-1:0]   sq_rad;
	logic              sq_done;
	logic [RT_W-1:0]   sq_root;
	part_t             pre;
	part_t             pim;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = paddr[2] ? {16'd0, beta_q} : {31'd0, learn_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q <= 1'b1;
			beta_q  <= BETA_RST;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				beta_q <= pwdata[FAC_W-1:0];
			end else begin
				learn_q <= pwdata[0];
			end
		end
	end

	assign bin_ready  = (state_q == ST_IDLE) && !clr_busy_q;
	assign bin_accept = bin_valid && bin_ready;

	assign mag_re  = re_s1[SW-1] ? SW'(-re_s1) : SW'(re_s1);
	assign mag_im  = im_s1[SW-1] ? SW'(-im_s1) : SW'(im_s1);
	assign sq_re   = mag_re * mag_re;
	assign sq_im   = mag_im * mag_im;
	assign p_nx    = sq_re + sq_im;
	assign mul_op  = (state_q == ST_MULI) ? mag_im : mag_re;
	assign prod_nx = mul_op * s_q;
	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(p_q);
	assign acc_nx  = {acc_q[ACC_W-2:0], 1'b0} + (fac_q[FAC_W-1] ? ACC_W'(n_q) : '0);
	assign p_ext   = A_W'(p_q);
	assign t_sub   = (p_ext > a_q) ? p_ext - a_q : '0;
	assign c_nx    = (t_sub < A_W'(f_q)) ? f_q : t_sub[SUM_W-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_s1;
		mem_wd = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == ST_WB && frames_q < FW'(MAX_NOISE_FRAMES)) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[pos_q];
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = DIV_NW'(prod_q) + DIV_NW'(m_q >> 1);
		div_den   = m_q;
		case (state_q)
			ST_RD: begin
				div_start = !learn_s1 && (frames_q != '0);
				div_num   = DIV_NW'(rdata_q);
				div_den   = DIV_DW'(frames_q);
			end
			ST_STR, ST_STI: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		sq_start = 1'b0;
		sq_rad   = {c_nx, {SQRT_SH{1'b0}}};
		case (state_q)
			ST_CLN: begin
				sq_start = 1'b1;
			end
			ST_SQS: begin
				sq_start = sq_done && (p_q != '0);
				sq_rad   = {{(SQ_W-PW-SQRT_SH){1'b0}}, p_q, {SQRT_SH{1'b0}}};
			end
			default: begin
				sq_start = 1'b0;
			end
		endcase
	end

	ssbg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ssbg_isqrt #(.W(SQ_W)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.root   (sq_root)
	);

	// a zero bin has both signs clear and qim_q at zero, so these cover it too
	assign pre = sat_part(re_s1[SW-1], qre_q);
	assign pim = sat_part(im_s1[SW-1], qim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_busy_q  <= 1'b1;
			clr_q       <= '0;
			pos_q       <= '0;
			frames_q    <= '0;
			mcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == PSW'(BINS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (bin_accept) begin
						state_q <= ST_RD;
						if (frame_end || pos_q == PSW'(BINS - 1)) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_RD: begin
					mcnt_q <= '0;
					if (learn_s1) begin
						state_q <= ST_WB;
					end else if (frames_q != '0) begin
						state_q <= ST_DIVN;
					end else begin
						state_q <= ST_MULA;
					end
				end
				ST_WB: begin
					if (fend_s1 && frames_q < FW'(MAX_NOISE_FRAMES)) begin
						frames_q <= frames_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_DIVN: begin
					mcnt_q <= '0;
					if (div_done) begin
						state_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == MCW'(FAC_W - 1)) begin
						state_q <= ST_MULF;
					end
				end
				ST_MULF: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == MCW'(FAC_W - 1)) begin
						state_q <= ST_CLN;
					end
				end
				ST_CLN: begin
					state_q <= ST_SQS;
				end
				ST_SQS: begin
					if (sq_done) begin
						state_q <= (p_q == '0) ? ST_OUT : ST_SQM;
					end
				end
				ST_SQM: begin
					if (sq_done) begin
						state_q <= ST_MULR;
					end
				end
				ST_MULR: begin
					state_q <= ST_STR;
				end
				ST_STR: begin
					state_q <= ST_DVR;
				end
				ST_DVR: begin
					if (div_done) begin
						state_q <= ST_MULI;
					end
				end
				ST_MULI: begin
					state_q <= ST_STI;
				end
				ST_STI: begin
					state_q <= ST_DVI;
				end
				ST_DVI: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (bin_accept) begin
					re_s1    <= bin_re;
					im_s1    <= bin_im;
					alpha_s1 <= sub_factor;
					fend_s1  <= frame_end;
					learn_s1 <= learn_q;
					pos_s1   <= pos_q;
				end
			end
			ST_RD: begin
				p_q   <= p_nx;
				sum_q <= rdata_q;
				n_q   <= '0;
				acc_q <= '0;
				fac_q <= alpha_s1;
			end
			ST_WB: begin
				p_q <= p_q;
			end
			ST_DIVN: begin
				if (div_done) begin
					n_q <= div_quo[SUM_W-1:0];
				end
			end
			ST_MULA: begin
				if (mcnt_q == MCW'(FAC_W - 1)) begin
					a_q   <= acc_nx[ACC_W-1:ALPHA_SH];
					acc_q <= '0;
					fac_q <= beta_q;
				end else begin
					acc_q <= acc_nx;
					fac_q <= {fac_q[FAC_W-2:0], 1'b0};
				end
			end
			ST_MULF: begin
				acc_q <= acc_nx;
				fac_q <= {fac_q[FAC_W-2:0], 1'b0};
				if (mcnt_q == MCW'(FAC_W - 1)) begin
					f_q <= acc_nx[ACC_W-1:BETA_SH];
				end
			end
			ST_SQS: begin
				if (sq_done) begin
					s_q   <= sq_root;
					qre_q <= DIV_NW'((sq_root + RT_W'(16)) >> 5);
					qim_q <= '0;
				end
			end
			ST_SQM: begin
				if (sq_done) begin
					m_q <= sq_root;
				end
			end
			ST_MULR: begin
				prod_q <= prod_nx;
			end
			ST_DVR: begin
				if (div_done) begin
					qre_q <= div_quo;
				end
			end
			ST_MULI: begin
				prod_q <= prod_nx;
			end
			ST_DVI: begin
				if (div_done) begin
					qim_q <= div_quo;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || res_ready) begin
					ore_q   <= pre.v;
					oim_q   <= pim.v;
					oclip_q <= pre.clip || pim.clip;
					ofend_q <= fend_s1;
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign res_valid     = res_valid_q;
	assign clean_re      = ore_q;
	assign clean_im      = oim_q;
	assign frame_end_out = ofend_q;
	assign clipped       = oclip_q;

	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !bin_ready)
		else $error("bin accepted during memory clear");

	a_accept_rd: assert property (@(posedge clk) disable iff (!arst_n)
		bin_accept |=> (state_q == ST_RD))
		else $error("sequencer did not start on accepted beat");

	a_wb_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |=> (state_q == ST_IDLE))
		else $error("learn beat did not retire");

	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && clipped) |-> (clean_re == OUT_HI || clean_re == OUT_LO ||
		clean_im == OUT_HI || clean_im == OUT_LO))
		else $error("clip flag without saturated part");

	a_no_ovr: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> (res_valid_q && $stable(clean_re) &&
		$stable(clean_im) && $stable(clipped) && $stable(frame_end_out)))
		else $error("result overwritten while stalled");

endmodule
